FILE: rtl/grc_pkg.sv
// grc_pkg: shared constants, datapath operation codes and control structs
// for the grid ray column caster; used by grc_ctrl, grc_datapath and the top level
`timescale 1ns / 1ps
package grc_pkg;

   // screen and map geometry
   localparam int unsigned SCREEN_HEIGHT = 768;
   localparam int unsigned CENTER_ROW    = SCREEN_HEIGHT / 2;
   localparam int unsigned MAP_SIZE      = 32;
   localparam int unsigned MAP_DEPTH     = MAP_SIZE * MAP_SIZE;
   localparam int unsigned WALK_CAP      = 2 * (MAP_SIZE + 40);

   localparam logic [3:0]  OUTSIDE_CODE  = 4'd15;
   localparam logic [23:0] STEP_MAX      = 24'hFF_FFFF;
   localparam logic [33:0] DELTA_NONE    = 34'h2_0000_0000;
   localparam logic [33:0] DIV_ONE_Q32   = 34'h1_0000_0000;
   localparam logic [33:0] DIV_HEIGHT    = 34'(SCREEN_HEIGHT * 65536);
   localparam logic [33:0] DIV_TEX       = 34'h100_0000;
   localparam logic [8:0]  HALF_MAX      = 9'(CENTER_ROW - 1);
   localparam logic [7:0]  CAP_LAST      = 8'(WALK_CAP - 1);

   // configuration register indexes
   localparam logic [2:0] CSR_POS_X   = 3'd0;
   localparam logic [2:0] CSR_POS_Y   = 3'd1;
   localparam logic [2:0] CSR_DIR_X   = 3'd2;
   localparam logic [2:0] CSR_DIR_Y   = 3'd3;
   localparam logic [2:0] CSR_PLANE_X = 3'd4;
   localparam logic [2:0] CSR_PLANE_Y = 3'd5;

   // datapath operations
   localparam logic [4:0] OP_NONE   = 5'd0;
   localparam logic [4:0] OP_CLEAR  = 5'd1;
   localparam logic [4:0] OP_MAPWR  = 5'd2;
   localparam logic [4:0] OP_CAM    = 5'd3;
   localparam logic [4:0] OP_RAY    = 5'd4;
   localparam logic [4:0] OP_DIVX   = 5'd5;
   localparam logic [4:0] OP_TAKEDX = 5'd6;
   localparam logic [4:0] OP_DIVY   = 5'd7;
   localparam logic [4:0] OP_TAKEDY = 5'd8;
   localparam logic [4:0] OP_MULX   = 5'd9;
   localparam logic [4:0] OP_TAKELX = 5'd10;
   localparam logic [4:0] OP_MULY   = 5'd11;
   localparam logic [4:0] OP_TAKELY = 5'd12;
   localparam logic [4:0] OP_STEP   = 5'd13;
   localparam logic [4:0] OP_READ   = 5'd14;
   localparam logic [4:0] OP_CHECK  = 5'd15;
   localparam logic [4:0] OP_PERP   = 5'd16;
   localparam logic [4:0] OP_DIVH   = 5'd17;
   localparam logic [4:0] OP_TAKEH  = 5'd18;
   localparam logic [4:0] OP_DIVS   = 5'd19;
   localparam logic [4:0] OP_TAKES  = 5'd20;
   localparam logic [4:0] OP_MULH   = 5'd21;
   localparam logic [4:0] OP_OUTLD  = 5'd22;

   typedef struct packed {
      logic [4:0] op;
   } grc_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_busy;
      logic mul_busy;
      logic cell_stop;
      logic cap_last;
      logic out_free;
   } grc_status_type;

endpackage

FILE: rtl/grc_div.sv
// grc_div: restoring divider, one quotient bit per cycle
// depends on nothing but its ports
`timescale 1ns / 1ps
module grc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [33:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [33:0] quotient
);

   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [33:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] rem_sh;
   logic [33:0] diff;

   // one restoring step
   always_comb begin
      rem_sh = {rem_ff, quo_ff[33]};
      diff   = {1'b0, rem_sh} - {2'b00, dvs_ff};
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = 6'd34;
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (cnt_ff != 6'd0) begin
         cnt_in = cnt_ff - 6'd1;
         rem_in = diff[33] ? rem_sh[31:0] : diff[31:0];
         quo_in = {quo_ff[32:0], ~diff[33]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = cnt_ff != 6'd0;
   assign quotient = quo_ff;

endmodule

FILE: rtl/grc_datapath.sv
// grc_datapath: configuration registers, tile map memory, ray setup,
// serial multiplier, DDA walk registers and result register; uses grc_pkg, grc_div
`timescale 1ns / 1ps
module grc_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  grc_pkg::grc_cmd_type    cmd,
   output grc_pkg::grc_status_type status,
   input  logic [9:0]              req_column,
   input  logic [4:0]              req_tile_row,
   input  logic [4:0]              req_tile_col,
   input  logic [3:0]              req_tile_value,
   input  logic                    csr_write,
   input  logic [2:0]              csr_index,
   input  logic [20:0]             csr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [8:0]              rsp_wall_top,
   output logic [9:0]              rsp_wall_bottom,
   output logic [7:0]              rsp_tex_column,
   output logic                    rsp_x_side,
   output logic [23:0]             rsp_tex_step,
   output logic [3:0]              rsp_hit_tile
);

   // configuration registers
   logic [20:0]        pos_x_ff, pos_y_ff;
   logic signed [17:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= 21'd720896;
         pos_y_ff   <= 21'd655360;
         dir_x_ff   <= 18'sd0;
         dir_y_ff   <= -18'sd65536;
         plane_x_ff <= 18'sd43254;
         plane_y_ff <= 18'sd0;
      end else if (csr_write) begin
         case (csr_index)
            grc_pkg::CSR_POS_X:   pos_x_ff   <= csr_data;
            grc_pkg::CSR_POS_Y:   pos_y_ff   <= csr_data;
            grc_pkg::CSR_DIR_X:   dir_x_ff   <= csr_data[17:0];
            grc_pkg::CSR_DIR_Y:   dir_y_ff   <= csr_data[17:0];
            grc_pkg::CSR_PLANE_X: plane_x_ff <= csr_data[17:0];
            grc_pkg::CSR_PLANE_Y: plane_y_ff <= csr_data[17:0];
            default: ;
         endcase
      end
   end

   // tile map memory with clearing sweep after reset
   logic [3:0] map_mem [grc_pkg::MAP_DEPTH];
   logic [9:0] clr_ff;
   logic [3:0] rd_ff;
   logic signed [6:0] cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.op == grc_pkg::OP_CLEAR) begin
         clr_ff <= clr_ff + 10'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == grc_pkg::OP_CLEAR) begin
         map_mem[clr_ff] <= 4'd0;
      end else if (cmd.op == grc_pkg::OP_MAPWR) begin
         map_mem[{req_tile_row, req_tile_col}] <= req_tile_value;
      end
      if (cmd.op == grc_pkg::OP_READ) begin
         rd_ff <= map_mem[{cy_ff[4:0], cx_ff[4:0]}];
      end
   end

   // ray setup: camera products, then ray components
   logic signed [17:0] camx;
   logic signed [35:0] prodx_ff, prody_ff;
   logic signed [19:0] rx_ff, ry_ff, rx_neg_val, ry_neg_val;
   logic [18:0]        rx_abs, ry_abs;
   logic               rx_neg, ry_neg, rx_zero, ry_zero;

   assign camx = $signed({1'b0, req_column, 7'b0}) - 18'sd65536;

   always_ff @(posedge clock) begin
      if (cmd.op == grc_pkg::OP_CAM) begin
         prodx_ff <= plane_x_ff * camx;
         prody_ff <= plane_y_ff * camx;
      end
      if (cmd.op == grc_pkg::OP_RAY) begin
         rx_ff <= {{2{dir_x_ff[17]}}, dir_x_ff} + prodx_ff[35:16];
         ry_ff <= {{2{dir_y_ff[17]}}, dir_y_ff} + prody_ff[35:16];
      end
   end

   always_comb begin
      rx_neg     = rx_ff[19];
      ry_neg     = ry_ff[19];
      rx_zero    = rx_ff == 20'sd0;
      ry_zero    = ry_ff == 20'sd0;
      rx_neg_val = -rx_ff;
      ry_neg_val = -ry_ff;
      rx_abs     = rx_neg ? rx_neg_val[18:0] : rx_ff[18:0];
      ry_abs     = ry_neg ? ry_neg_val[18:0] : ry_ff[18:0];
   end

   // shared divider
   logic        div_start, div_busy;
   logic [33:0] div_dvd, div_q;
   logic [31:0] div_dvs;
   logic [31:0] perp_ff;
   logic [25:0] h_ff;

   always_comb begin
      div_start = 1'b1;
      div_dvd   = grc_pkg::DIV_ONE_Q32;
      div_dvs   = {13'b0, ry_abs};
      case (cmd.op)
         grc_pkg::OP_DIVX: div_dvs = {13'b0, rx_abs};
         grc_pkg::OP_DIVY: div_dvs = {13'b0, ry_abs};
         grc_pkg::OP_DIVH: begin
            div_dvd = grc_pkg::DIV_HEIGHT;
            div_dvs = perp_ff;
         end
         grc_pkg::OP_DIVS: begin
            div_dvd = grc_pkg::DIV_TEX;
            div_dvs = {6'b0, h_ff};
         end
         default: div_start = 1'b0;
      endcase
   end

   grc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // serial shift-add multiplier
   logic        mul_start, xs_ff;
   logic [33:0] mul_cand;
   logic [18:0] mul_plier;
   logic [16:0] fcomp_x, fcomp_y;
   logic [52:0] acc_ff, acc_in, cand_ff, cand_in;
   logic [18:0] plier_ff, plier_in;
   logic        mul_busy_ff, mul_busy_in;
   logic [33:0] dx_ff, dy_ff;

   always_comb begin
      fcomp_x   = 17'h1_0000 - {1'b0, pos_x_ff[15:0]};
      fcomp_y   = 17'h1_0000 - {1'b0, pos_y_ff[15:0]};
      mul_start = 1'b1;
      mul_cand  = dx_ff;
      mul_plier = rx_neg ? {3'b0, pos_x_ff[15:0]} : {2'b0, fcomp_x};
      case (cmd.op)
         grc_pkg::OP_MULX: ;
         grc_pkg::OP_MULY: begin
            mul_cand  = dy_ff;
            mul_plier = ry_neg ? {3'b0, pos_y_ff[15:0]} : {2'b0, fcomp_y};
         end
         grc_pkg::OP_MULH: begin
            mul_cand  = {2'b0, perp_ff};
            mul_plier = xs_ff ? ry_abs : rx_abs;
         end
         default: mul_start = 1'b0;
      endcase

      acc_in      = acc_ff;
      cand_in     = cand_ff;
      plier_in    = plier_ff;
      mul_busy_in = mul_busy_ff;
      if (mul_start) begin
         acc_in      = '0;
         cand_in     = {19'b0, mul_cand};
         plier_in    = mul_plier;
         mul_busy_in = mul_plier != 19'd0;
      end else if (mul_busy_ff) begin
         if (plier_ff[0]) begin
            acc_in = acc_ff + cand_ff;
         end
         cand_in     = {cand_ff[51:0], 1'b0};
         plier_in    = {1'b0, plier_ff[18:1]};
         mul_busy_in = plier_ff[18:1] != 18'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff <= 1'b0;
      end else begin
         mul_busy_ff <= mul_busy_in;
      end
      acc_ff   <= acc_in;
      cand_ff  <= cand_in;
      plier_ff <= plier_in;
   end

   // dda walk
   logic [47:0] ldx_ff, ldy_ff, dx_w, dy_w, perp_diff;
   logic [7:0]  count_ff;
   logic [3:0]  code_ff;
   logic [23:0] step_ff;
   logic        outside, ldx_less;

   assign dx_w     = {14'b0, dx_ff};
   assign dy_w     = {14'b0, dy_ff};
   assign ldx_less = ldx_ff < ldy_ff;
   assign outside  = cx_ff[6] | cx_ff[5] | cy_ff[6] | cy_ff[5];
   assign perp_diff = xs_ff ? ldx_ff - dx_w : ldy_ff - dy_w;

   always_ff @(posedge clock) begin
      case (cmd.op)
         grc_pkg::OP_CAM: begin
            cx_ff    <= {2'b0, pos_x_ff[20:16]};
            cy_ff    <= {2'b0, pos_y_ff[20:16]};
            count_ff <= '0;
            xs_ff    <= 1'b0;
         end
         grc_pkg::OP_TAKEDX: dx_ff <= rx_zero ? grc_pkg::DELTA_NONE : div_q;
         grc_pkg::OP_TAKEDY: dy_ff <= ry_zero ? grc_pkg::DELTA_NONE : div_q;
         grc_pkg::OP_TAKELX: ldx_ff <= {11'b0, acc_ff[52:16]};
         grc_pkg::OP_TAKELY: ldy_ff <= {11'b0, acc_ff[52:16]};
         grc_pkg::OP_STEP: begin
            if (ldx_less) begin
               cx_ff  <= rx_neg ? cx_ff - 7'sd1 : cx_ff + 7'sd1;
               ldx_ff <= ldx_ff + dx_w;
               xs_ff  <= 1'b1;
            end else begin
               cy_ff  <= ry_neg ? cy_ff - 7'sd1 : cy_ff + 7'sd1;
               ldy_ff <= ldy_ff + dy_w;
               xs_ff  <= 1'b0;
            end
         end
         grc_pkg::OP_CHECK: begin
            count_ff <= count_ff + 8'd1;
            code_ff  <= (outside || rd_ff == 4'd0) ? grc_pkg::OUTSIDE_CODE : rd_ff;
         end
         grc_pkg::OP_PERP:
            perp_ff <= (perp_diff[47:32] != 16'd0) ? 32'hFFFF_FFFF : perp_diff[31:0];
         grc_pkg::OP_TAKEH: h_ff <= div_q[25:0];
         grc_pkg::OP_TAKES:
            step_ff <= (h_ff == 26'd0 || div_q[33:24] != 10'd0) ?
                       grc_pkg::STEP_MAX : div_q[23:0];
         default: ;
      endcase
   end

   // result formation
   logic        perp_zero, mirror, ray_neg_sel;
   logic [31:0] hp;
   logic [15:0] frac;
   logic [7:0]  tex;
   logic [8:0]  half;

   always_comb begin
      perp_zero   = perp_ff == 32'd0;
      ray_neg_sel = xs_ff ? ry_neg : rx_neg;
      hp          = ray_neg_sel ? (32'd0 - acc_ff[31:0]) : acc_ff[31:0];
      frac        = (xs_ff ? pos_y_ff[15:0] : pos_x_ff[15:0]) + hp[31:16];
      mirror      = (xs_ff && !rx_neg && !rx_zero) || (!xs_ff && ry_neg);
      tex         = mirror ? ~frac[15:8] : frac[15:8];
      if (perp_zero || h_ff[25:1] > {16'b0, grc_pkg::HALF_MAX}) begin
         half = grc_pkg::HALF_MAX;
      end else begin
         half = h_ff[9:1];
      end
   end

   // output register
   logic        rsp_valid_ff;
   logic [8:0]  top_ff;
   logic [9:0]  bottom_ff;
   logic [7:0]  tex_ff;
   logic        xs_out_ff;
   logic [23:0] step_out_ff;
   logic [3:0]  tile_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == grc_pkg::OP_OUTLD) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == grc_pkg::OP_OUTLD) begin
         top_ff      <= 9'(grc_pkg::CENTER_ROW) - half;
         bottom_ff   <= 10'(grc_pkg::CENTER_ROW) + {1'b0, half};
         tex_ff      <= tex;
         xs_out_ff   <= xs_ff;
         step_out_ff <= perp_zero ? 24'd0 : step_ff;
         tile_ff     <= code_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_wall_top    = top_ff;
   assign rsp_wall_bottom = bottom_ff;
   assign rsp_tex_column  = tex_ff;
   assign rsp_x_side      = xs_out_ff;
   assign rsp_tex_step    = step_out_ff;
   assign rsp_hit_tile    = tile_ff;

   // status toward the controller
   always_comb begin
      status.clear_last = clr_ff == 10'(grc_pkg::MAP_DEPTH - 1);
      status.div_busy   = div_busy;
      status.mul_busy   = mul_busy_ff;
      status.cell_stop  = outside || rd_ff != 4'd0;
      status.cap_last   = count_ff == grc_pkg::CAP_LAST;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

endmodule

FILE: rtl/grc_ctrl.sv
// grc_ctrl: sequencer for map clear, tile writes and the column cast
// depends on grc_pkg
`timescale 1ns / 1ps
module grc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_mode,
   output logic                    req_stall,
   input  grc_pkg::grc_status_type status,
   output grc_pkg::grc_cmd_type    cmd
);

   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_RAY   = 5'd2;
   localparam logic [4:0] S_DIVX  = 5'd3;
   localparam logic [4:0] S_WDX   = 5'd4;
   localparam logic [4:0] S_DIVY  = 5'd5;
   localparam logic [4:0] S_WDY   = 5'd6;
   localparam logic [4:0] S_MULX  = 5'd7;
   localparam logic [4:0] S_WLX   = 5'd8;
   localparam logic [4:0] S_MULY  = 5'd9;
   localparam logic [4:0] S_WLY   = 5'd10;
   localparam logic [4:0] S_STEP  = 5'd11;
   localparam logic [4:0] S_READ  = 5'd12;
   localparam logic [4:0] S_CHECK = 5'd13;
   localparam logic [4:0] S_PERP  = 5'd14;
   localparam logic [4:0] S_DIVH  = 5'd15;
   localparam logic [4:0] S_WH    = 5'd16;
   localparam logic [4:0] S_DIVS  = 5'd17;
   localparam logic [4:0] S_WS    = 5'd18;
   localparam logic [4:0] S_MULH  = 5'd19;
   localparam logic [4:0] S_WHIT  = 5'd20;
   localparam logic [4:0] S_OUT   = 5'd21;

   logic [4:0] state_ff, state_in;

   // next state and datapath operation
   always_comb begin
      state_in = state_ff;
      cmd.op   = grc_pkg::OP_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = grc_pkg::OP_CLEAR;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_mode) begin
                  cmd.op   = grc_pkg::OP_CAM;
                  state_in = S_RAY;
               end else begin
                  cmd.op = grc_pkg::OP_MAPWR;
               end
            end
         end
         S_RAY: begin
            cmd.op   = grc_pkg::OP_RAY;
            state_in = S_DIVX;
         end
         S_DIVX: begin
            cmd.op   = grc_pkg::OP_DIVX;
            state_in = S_WDX;
         end
         S_WDX: begin
            if (!status.div_busy) begin
               cmd.op   = grc_pkg::OP_TAKEDX;
               state_in = S_DIVY;
            end
         end
         S_DIVY: begin
            cmd.op   = grc_pkg::OP_DIVY;
            state_in = S_WDY;
         end
         S_WDY: begin
            if (!status.div_busy) begin
               cmd.op   = grc_pkg::OP_TAKEDY;
               state_in = S_MULX;
            end
         end
         S_MULX: begin
            cmd.op   = grc_pkg::OP_MULX;
            state_in = S_WLX;
         end
         S_WLX: begin
            if (!status.mul_busy) begin
               cmd.op   = grc_pkg::OP_TAKELX;
               state_in = S_MULY;
            end
         end
         S_MULY: begin
            cmd.op   = grc_pkg::OP_MULY;
            state_in = S_WLY;
         end
         S_WLY: begin
            if (!status.mul_busy) begin
               cmd.op   = grc_pkg::OP_TAKELY;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            cmd.op   = grc_pkg::OP_STEP;
            state_in = S_READ;
         end
         S_READ: begin
            cmd.op   = grc_pkg::OP_READ;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.op   = grc_pkg::OP_CHECK;
            state_in = (status.cell_stop || status.cap_last) ? S_PERP : S_STEP;
         end
         S_PERP: begin
            cmd.op   = grc_pkg::OP_PERP;
            state_in = S_DIVH;
         end
         S_DIVH: begin
            cmd.op   = grc_pkg::OP_DIVH;
            state_in = S_WH;
         end
         S_WH: begin
            if (!status.div_busy) begin
               cmd.op   = grc_pkg::OP_TAKEH;
               state_in = S_DIVS;
            end
         end
         S_DIVS: begin
            cmd.op   = grc_pkg::OP_DIVS;
            state_in = S_WS;
         end
         S_WS: begin
            if (!status.div_busy) begin
               cmd.op   = grc_pkg::OP_TAKES;
               state_in = S_MULH;
            end
         end
         S_MULH: begin
            cmd.op   = grc_pkg::OP_MULH;
            state_in = S_WHIT;
         end
         S_WHIT: begin
            if (!status.mul_busy) state_in = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.op   = grc_pkg::OP_OUTLD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

FILE: rtl/grid_ray_column_caster.sv
// grid_ray_column_caster: top level joining controller and datapath
// depends on grc_pkg, grc_ctrl, grc_datapath (and grc_div below it)
`timescale 1ns / 1ps
// A tile write (mode 0) is done in the idle state. A column cast (mode 1)
// runs one request at a time: camera and ray setup, four divisions on the
// shared restoring divider (ray deltas, wall height, texture step), three
// shift-add multiplies, and a step, a tile read and a check for each grid
// cell visited by the walk, with at most 144 cells, plus any wait for the
// output register.
// A new request is taken while the previous result waits in the output
// register. After reset the 1024-entry tile map is cleared, one entry per
// cycle, so no request is accepted until the clearing sweep is done.
module grid_ray_column_caster (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [9:0]  req_column,
   input  logic [4:0]  req_tile_row,
   input  logic [4:0]  req_tile_col,
   input  logic [3:0]  req_tile_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  rsp_wall_top,
   output logic [9:0]  rsp_wall_bottom,
   output logic [7:0]  rsp_tex_column,
   output logic        rsp_x_side,
   output logic [23:0] rsp_tex_step,
   output logic [3:0]  rsp_hit_tile,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [20:0] csr_data
);

   grc_pkg::grc_cmd_type    cmd;
   grc_pkg::grc_status_type status;

   grc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   grc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_column      (req_column),
      .req_tile_row    (req_tile_row),
      .req_tile_col    (req_tile_col),
      .req_tile_value  (req_tile_value),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_wall_top    (rsp_wall_top),
      .rsp_wall_bottom (rsp_wall_bottom),
      .rsp_tex_column  (rsp_tex_column),
      .rsp_x_side      (rsp_x_side),
      .rsp_tex_step    (rsp_tex_step),
      .rsp_hit_tile    (rsp_hit_tile)
   );

   // wall span is centered on the screen
   a_span_centered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (11'(rsp_wall_top) + 11'(rsp_wall_bottom) == 11'd768))
      else $error("wall span not centered");

   // a new result only appears while a cast is in progress
   a_result_from_cast: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(req_stall))
      else $error("result without a cast");

   // zero distance gives a zero texture step and full span
   a_full_span_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tex_step == 24'd0) |-> (rsp_wall_top == 9'd1))
      else $error("zero step without full span");

endmodule
